[rtl/core/obda_pkg.sv]
// Shared types, widths and codes for the OFDM block deinterleaver address generator.
`timescale 1ns / 1ps
package obda_pkg;

  localparam int SOFT_W   = 8;   // soft value width
  localparam int CB_W     = 9;   // coded_bits_per_symbol register width
  localparam int BPS_W    = 4;   // bits_per_subcarrier register width
  localparam int POS_W    = 9;   // bit counter and position width
  localparam int SYMNUM_W = 10;  // reported symbol number width
  localparam int N_W      = 10;  // effective coded bits, holds up to 512
  localparam int S_W      = 3;   // group size s, 1..7
  localparam int I_W      = 10;  // first permutation result, up to 517
  localparam int Q_W      = 8;   // quotients of 16*x/N, up to 172
  localparam int DVD_W    = 14;  // divider dividend width, 16*i up to 8272
  localparam int DVS_W    = 10;  // divider divisor width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam int MIN_CODED_BITS     = 48;
  localparam int MAX_CODED_BITS     = 384;
  localparam int DEF_MAX_SYMBOLS    = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODED_BITS = 1'b0,
    REG_BITS_PER_SC = 1'b1
  } reg_idx_t;

  // divider operand selection
  typedef enum logic [1:0] {
    SEL_Q1 = 2'd0,  // 16*k / N
    SEL_KS = 2'd1,  // k / s
    SEL_KQ = 2'd2,  // (k + q1) mod s
    SEL_Q2 = 2'd3   // 16*i / N
  } div_sel_t;

  typedef struct packed {
    logic signed [SOFT_W-1:0] soft_value;
    logic                     frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SOFT_W-1:0] soft_out;
    logic [POS_W-1:0]         position_in_symbol;
    logic [SYMNUM_W-1:0]      symbol_number;
    logic                     symbol_last;
  } out_item_t;

  typedef struct packed {
    reg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_q1;
    logic     latch_qa;
    logic     calc_i;
    logic     latch_prod;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/obda_in_if.sv]
// Input item channel: one soft bit and the frame start flag.
`timescale 1ns / 1ps
interface obda_in_if;
  logic               valid;
  logic               ready;
  obda_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/obda_out_if.sv]
// Result item channel: soft bit, deinterleaved position, symbol number and last flag.
`timescale 1ns / 1ps
interface obda_out_if;
  logic                valid;
  logic                ready;
  obda_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/obda_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface obda_cfg_if;
  logic                valid;
  logic                ready;
  obda_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/obda_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module obda_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [obda_pkg::DVD_W-1:0] dividend,
  input  logic [obda_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [obda_pkg::DVD_W-1:0] quot,
  output logic [obda_pkg::DVS_W-1:0] rem
);
  import obda_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dsor;
  logic [DVS_W-1:0]   rmd;
  logic [DVS_W:0]     rem_sh;
  logic [DVS_W:0]     diff;

  assign rem_sh = {rmd, dvd[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dvd shifts out dividend bits and collects quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsor <= divisor;
      rmd  <= '0;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        rmd <= diff[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rmd <= rem_sh[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quot = dvd;
  assign rem  = rmd;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

[rtl/core/obda_dp.sv]
// Datapath: config registers, bit and symbol counters, permutation arithmetic, output register.
`timescale 1ns / 1ps
module obda_dp #(
  parameter int MAX_SYMBOLS = obda_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  obda_pkg::cfg_item_t   cfg_item,
  input  obda_pkg::in_item_t    in_item,
  input  obda_pkg::cmd_t        cmd,
  output obda_pkg::sts_t        sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output obda_pkg::out_item_t   out_item
);
  import obda_pkg::*;

  localparam int SC_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [SC_W-1:0] SYM_MAX = SC_W'(MAX_SYMBOLS - 1);
  localparam logic [N_W-1:0]  N_MIN   = N_W'(MIN_CODED_BITS);
  localparam logic [N_W-1:0]  N_MAX   = N_W'(MAX_CODED_BITS);

  logic [CB_W-1:0]  coded_bits;
  logic [BPS_W-1:0] bits_per_sc;
  logic [POS_W-1:0] bit_counter;
  logic [SC_W-1:0]  symbol_counter;

  logic [N_W-1:0]   n_eff;
  logic [S_W-1:0]   s_grp;
  logic [POS_W-1:0] k_sel;
  logic [SC_W-1:0]  sym_sel;
  logic             last_sel;

  // per-item registers
  logic signed [SOFT_W-1:0] soft_r;
  logic [POS_W-1:0]         k_r;
  logic [SC_W-1:0]          sym_r;
  logic                     last_r;
  logic [Q_W-1:0]           q1_r;
  logic [POS_W-1:0]         qa_r;
  logic [I_W-1:0]           i_r;
  logic [POS_W-1:0]         prod_r;

  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;
  logic [N_W+Q_W-1:0] prod_full;
  logic [I_W+S_W-1:0] i_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      coded_bits  <= CB_W'(MIN_CODED_BITS);
      bits_per_sc <= BPS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_item.index)
        REG_CODED_BITS:  coded_bits  <= cfg_item.data[CB_W-1:0];
        REG_BITS_PER_SC: bits_per_sc <= cfg_item.data[BPS_W-1:0];
      endcase
    end
  end

  always_comb begin
    if ({1'b0, coded_bits} < N_MIN)      n_eff = N_MIN;
    else if ({1'b0, coded_bits} > N_MAX) n_eff = N_MAX;
    else                                 n_eff = {1'b0, coded_bits};
    s_grp = (bits_per_sc[BPS_W-1:1] == '0) ? S_W'(1) : bits_per_sc[BPS_W-1:1];
  end

  assign k_sel    = in_item.frame_start ? '0 : bit_counter;
  assign sym_sel  = in_item.frame_start ? '0 : symbol_counter;
  assign last_sel = ({1'b0, k_sel} >= (n_eff - 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_counter    <= '0;
      symbol_counter <= '0;
    end else if (cmd.load) begin
      if (last_sel) begin
        bit_counter <= '0;
        symbol_counter <= (sym_sel < SYM_MAX) ? sym_sel + 1'b1 : sym_sel;
      end else begin
        bit_counter    <= k_sel + 1'b1;
        symbol_counter <= sym_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      soft_r <= in_item.soft_value;
      k_r    <= k_sel;
      sym_r  <= sym_sel;
      last_r <= last_sel;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      SEL_Q1: begin
        div_dvd = DVD_W'({k_r, 4'b0000});
        div_dvs = n_eff;
      end
      SEL_KS: begin
        div_dvd = DVD_W'(k_r);
        div_dvs = DVS_W'(s_grp);
      end
      SEL_KQ: begin
        div_dvd = DVD_W'(k_r) + DVD_W'(q1_r);
        div_dvs = DVS_W'(s_grp);
      end
      SEL_Q2: begin
        div_dvd = DVD_W'({i_r, 4'b0000});
        div_dvs = n_eff;
      end
    endcase
  end

  obda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign i_full    = s_grp * qa_r + (I_W + S_W)'(div_rem[S_W-1:0]);
  assign prod_full = (n_eff - 1'b1) * div_quot[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch_q1)   q1_r   <= div_quot[Q_W-1:0];
    if (cmd.latch_qa)   qa_r   <= div_quot[POS_W-1:0];
    if (cmd.calc_i)     i_r    <= i_full[I_W-1:0];
    if (cmd.latch_prod) prod_r <= prod_full[POS_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.soft_out           <= soft_r;
      out_item.position_in_symbol <= {i_r[POS_W-5:0], 4'b0000} - prod_r;
      out_item.symbol_number      <= SYMNUM_W'(sym_r);
      out_item.symbol_last        <= last_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

[rtl/core/obda_ctrl.sv]
// Controller: sequences the four divisions, the multiplies and the output load per item.
`timescale 1ns / 1ps
module obda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_accept,
  input  obda_pkg::sts_t  sts,
  output obda_pkg::cmd_t  cmd,
  output logic            in_ready
);
  import obda_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_DIV1  = 8'b0000_0100,
    S_DIV2  = 8'b0000_1000,
    S_DIV3  = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_DIV4  = 8'b0100_0000,
    S_PROD  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_Q1;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd.load   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_Q1;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.latch_q1  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_KS;
          state_next    = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.latch_qa  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_KQ;
          state_next    = S_DIV3;
        end
      end
      S_DIV3: begin
        if (sts.div_done) begin
          cmd.calc_i = 1'b1;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_Q2;
        state_next    = S_DIV4;
      end
      S_DIV4: begin
        if (sts.div_done) begin
          cmd.latch_prod = 1'b1;
          state_next     = S_PROD;
        end
      end
      S_PROD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_LOAD)
    else $error("accepted item did not start a permutation");
  a_idle_no_done: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sts.div_done)
    else $error("divider finished with no item in flight");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while full");

endmodule

[rtl/core/ofdm_block_deinterleaver_address.sv]
// Top level of the 802.11 OFDM block deinterleaver address generator.
// Flow: an accepted item is loaded, then runs three 14-step divisions of the shared
//   restoring divider, forms i, runs a fourth division and ends with the final
//   subtract into the output register, from which it shows on dout.
// Items: one item is in flight at a time on the single shared divider; a result
//   still held in the output register delays the next item's final subtract.
// Reset (rst, synchronous): counters to zero, config to 48 coded bits and 1 bit per
//   subcarrier, output empty, controller idle.
`timescale 1ns / 1ps
module ofdm_block_deinterleaver_address #(
  parameter int MAX_SYMBOLS = obda_pkg::DEF_MAX_SYMBOLS
) (
  input logic         clk,
  input logic         rst,
  obda_cfg_if.sink    cfg,
  obda_in_if.sink     din,
  obda_out_if.source  dout
);
  import obda_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic in_accept;

  // Config writes are taken at any time; the user only writes while idle.
  assign cfg.ready = 1'b1;

  // The next item is taken as soon as the controller is back in idle, even if
  // the previous result still sits in the output register.
  assign din.ready = in_ready;
  assign in_accept = din.valid && in_ready;

  // Sequencing: k = bit index (zero on frame start), then
  //   q1 = 16k/N, qa = k/s, r = (k+q1) mod s, i = s*qa + r,
  //   q2 = 16i/N, pos = 16i - (N-1)*q2 (low 9 bits).
  obda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  // Counters advance at accept time; symbol count saturates at MAX_SYMBOLS-1.
  obda_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_item  (cfg.data),
    .in_item   (din.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (dout.ready),
    .out_valid (dout.valid),
    .out_item  (dout.data)
  );

endmodule
